// File: rtl/core/cbeq_pkg.sv
// Shared types and constants of the cascaded biquad equalizer.
// Holds field widths, fixed-point formats, register and slot codes, and the
// controller-to-datapath command struct. Depends on nothing.
package cbeq_pkg;

    // Item field widths.
    localparam int SAMPLE_W     = 12;
    localparam int BAND_IDX_W   = 4;
    localparam int SLOT_W       = 3;
    localparam int COEF_IN_W    = 24;
    localparam int GAIN_W       = 16;
    localparam int BAND_CNT_W   = 4;

    // Widest band index the command struct carries (up to 32 bands).
    localparam int BAND_FIELD_W = 5;

    // Fixed-point formats.
    localparam int COEF_FRAC    = 20;
    localparam int STATE_FRAC   = 16;
    localparam int GAIN_FRAC    = 12;
    localparam int SAMPLE_ZERO  = 2048;
    localparam int SAMPLE_MAX   = 4095;

    // Operation codes of an input item.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Coefficient slots within one band.
    localparam int NUM_SLOTS = 5;
    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    // Configuration register indexes.
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_BAND_COUNT    = 2'd0;
    localparam logic [1:0] REG_FILTER_ENABLE = 2'd1;
    localparam logic [1:0] REG_OUT_GAIN      = 2'd2;

    typedef enum logic [1:0] {
        OPND_W1,
        OPND_W2,
        OPND_W0
    } t_opnd;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_Y_SUB,
        ACC_SUB,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic                    load_x;
        logic                    coef_wr;
        logic                    coef_rd;
        logic [BAND_FIELD_W-1:0] band;
        logic [SLOT_W-1:0]       slot;
        logic                    dly_rd;
        logic                    dly_wr;
        logic                    mul_en;
        t_opnd                   opnd;
        t_acc_op                 acc_op;
        logic                    w0_save;
        logic                    y_sat;
        logic                    gain_mul;
        logic                    out_load;
    } t_dp_cmd;

endpackage

// File: rtl/core/cbeq_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on cbeq_pkg for the field widths.
interface cbeq_item_if;
    import cbeq_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [SAMPLE_W-1:0]         sample_in;
    logic [BAND_IDX_W-1:0]       band_index;
    logic [SLOT_W-1:0]           coef_slot;
    logic signed [COEF_IN_W-1:0] coef_value;

    modport source (output valid, op, sample_in, band_index, coef_slot, coef_value,
                    input ready);
    modport sink   (input valid, op, sample_in, band_index, coef_slot, coef_value,
                    output ready);
endinterface

interface cbeq_result_if;
    import cbeq_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] audio_out;
    logic                clipped;

    modport source (output valid, audio_out, clipped, input ready);
    modport sink   (input valid, audio_out, clipped, output ready);
endinterface

// File: rtl/core/cbeq_ctrl.sv
// Sequencer of the equalizer: steps the shared MAC through the sections.
// Depends on cbeq_pkg for the command struct and codes.
module cbeq_ctrl #(
    parameter int MAX_BANDS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_valid,
    input  logic                                i_item_op,
    output logic                                o_item_ready,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [cbeq_pkg::BAND_CNT_W-1:0]     i_band_count,
    input  logic                                i_filter_enable,
    output cbeq_pkg::t_dp_cmd                   o_cmd
);
    import cbeq_pkg::*;

    localparam int CNT_NEED = $clog2(MAX_BANDS + 1);
    localparam int CW = (CNT_NEED > BAND_CNT_W) ? CNT_NEED : BAND_CNT_W;
    localparam int LAST_PHASE = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAND,
        S_TAIL,
        S_GAIN,
        S_OUT
    } t_state;

    t_state        r_state;
    logic [2:0]    r_phase;
    logic [CW-1:0] r_band;
    logic          r_out_valid;

    logic [CW-1:0] band_lim;
    logic          accept;
    logic          out_free;
    logic          last_band;
    logic          has_prev;

    assign band_lim  = (CW'(i_band_count) > CW'(MAX_BANDS)) ? CW'(MAX_BANDS)
                                                            : CW'(i_band_count);
    assign accept    = (r_state == S_IDLE) && i_item_valid;
    assign out_free  = !r_out_valid || i_out_ready;
    assign last_band = (r_band + CW'(1)) == band_lim;
    assign has_prev  = r_band != '0;

    assign o_item_ready = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.opnd     = OPND_W1;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.band     = BAND_FIELD_W'(r_band);
        case (r_state)
            S_IDLE: begin
                o_cmd.coef_wr = accept && (i_item_op == OP_COEF);
                o_cmd.load_x  = accept && (i_item_op == OP_SAMPLE);
            end
            S_BAND: begin
                case (r_phase)
                    3'd0: begin
                        o_cmd.dly_rd  = 1'b1;
                        o_cmd.coef_rd = 1'b1;
                        o_cmd.slot    = SLOT_A1;
                        // Last feed-forward term of the previous section.
                        o_cmd.acc_op  = has_prev ? ACC_ADD : ACC_HOLD;
                    end
                    3'd1: begin
                        o_cmd.coef_rd = 1'b1;
                        o_cmd.slot    = SLOT_A2;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.opnd    = OPND_W1;
                        o_cmd.y_sat   = has_prev;
                    end
                    3'd2: begin
                        o_cmd.coef_rd = 1'b1;
                        o_cmd.slot    = SLOT_B1;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.opnd    = OPND_W2;
                        o_cmd.acc_op  = ACC_Y_SUB;
                    end
                    3'd3: begin
                        o_cmd.coef_rd = 1'b1;
                        o_cmd.slot    = SLOT_B2;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.opnd    = OPND_W1;
                        o_cmd.acc_op  = ACC_SUB;
                    end
                    3'd4: begin
                        o_cmd.coef_rd = 1'b1;
                        o_cmd.slot    = SLOT_B0;
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.opnd    = OPND_W2;
                        o_cmd.acc_op  = ACC_LOAD;
                        o_cmd.w0_save = 1'b1;
                    end
                    default: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.opnd    = OPND_W0;
                        o_cmd.acc_op  = ACC_ADD;
                        o_cmd.dly_wr  = 1'b1;
                    end
                endcase
            end
            S_TAIL: begin
                if (r_phase == 3'd0) begin
                    o_cmd.acc_op = ACC_ADD;
                end else begin
                    o_cmd.y_sat = 1'b1;
                end
            end
            S_GAIN: begin
                o_cmd.gain_mul = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd.acc_op = ACC_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_band      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the output register as the old one leaves.
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_phase <= '0;
                    r_band  <= '0;
                    if (accept && (i_item_op == OP_SAMPLE)) begin
                        if (i_filter_enable && (band_lim != '0)) begin
                            r_state <= S_BAND;
                        end else begin
                            r_state <= S_GAIN;
                        end
                    end
                end
                S_BAND: begin
                    if (r_phase == 3'(LAST_PHASE)) begin
                        r_phase <= '0;
                        if (last_band) begin
                            r_state <= S_TAIL;
                        end else begin
                            r_band <= r_band + CW'(1);
                        end
                    end else begin
                        r_phase <= r_phase + 3'd1;
                    end
                end
                S_TAIL: begin
                    if (r_phase == 3'd0) begin
                        r_phase <= 3'd1;
                    end else begin
                        r_phase <= '0;
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/cbeq_dp.sv
// Datapath of the equalizer: coefficient and delay memories, one shared
// multiplier with accumulator, and the output gain stage. Depends on cbeq_pkg.
module cbeq_dp #(
    parameter int MAX_BANDS   = 10,
    parameter int COEF_WIDTH  = 24,
    parameter int STATE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cbeq_pkg::t_dp_cmd                    i_cmd,
    input  logic [cbeq_pkg::SAMPLE_W-1:0]        i_sample_in,
    input  logic [cbeq_pkg::BAND_IDX_W-1:0]      i_band_index,
    input  logic [cbeq_pkg::SLOT_W-1:0]          i_coef_slot,
    input  logic signed [cbeq_pkg::COEF_IN_W-1:0] i_coef_value,
    input  logic [cbeq_pkg::GAIN_W-1:0]          i_out_gain,
    output logic [cbeq_pkg::SAMPLE_W-1:0]        o_audio_out,
    output logic                                 o_clipped
);
    import cbeq_pkg::*;

    localparam int SW   = STATE_WIDTH;
    localparam int XW   = SAMPLE_W + STATE_FRAC;
    localparam int YW   = (SW > XW) ? SW : XW;
    localparam int PW   = COEF_WIDTH + SW;
    localparam int RW   = PW - COEF_FRAC + 1;
    localparam int AW   = ((RW > YW) ? RW : YW) + 2;
    localparam int BIW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CDEP = MAX_BANDS * NUM_SLOTS;
    localparam int CAW  = $clog2(CDEP);
    localparam int GW   = YW + GAIN_W + 1;
    localparam int GSH  = GAIN_FRAC + STATE_FRAC;
    localparam int OW   = GW + 1 - GSH + 1;

    localparam logic signed [AW-1:0] S_MAX =
        {{(AW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [AW-1:0] S_MIN = ~S_MAX;
    localparam logic signed [PW:0]   RND_P = (PW + 1)'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [GW:0]   RND_G = (GW + 1)'(1) <<< (GSH - 1);

    // Coefficient store, undefined until written.
    logic signed [COEF_WIDTH-1:0] coef_mem [CDEP];
    logic signed [COEF_WIDTH-1:0] r_coef;
    logic signed [COEF_WIDTH-1:0] coef_sat;
    logic [CAW-1:0]               coef_wr_addr;
    logic [CAW-1:0]               coef_rd_addr;
    logic                         coef_addr_ok;

    // Delay store, one row {w2, w1} per band, cleared through valid bits.
    logic [2*SW-1:0]      dly_mem [MAX_BANDS];
    logic [MAX_BANDS-1:0] r_dly_vld;
    logic [2*SW-1:0]      r_dly_q;
    logic                 r_dly_qv;
    logic [BIW-1:0]       band_sel;

    logic signed [SW-1:0] w1;
    logic signed [SW-1:0] w2;
    logic signed [SW-1:0] r_w0;
    logic signed [SW-1:0] opnd;
    logic signed [PW-1:0] r_prod;
    logic signed [PW:0]   p_sum;
    logic signed [RW-1:0] p_rnd;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] acc_sat;
    logic signed [YW-1:0] r_y;
    logic signed [SAMPLE_W:0] x_c;

    logic signed [GW-1:0] r_gprod;
    logic signed [GW:0]   g_sum;
    logic signed [OW-1:0] g_out;
    logic [SAMPLE_W-1:0]  r_audio_out;
    logic                 r_clipped;

    assign band_sel     = i_cmd.band[BIW-1:0];
    assign coef_addr_ok = (int'(i_band_index) < MAX_BANDS) && (int'(i_coef_slot) < NUM_SLOTS);
    assign coef_wr_addr = CAW'(8'(i_band_index) * 8'(NUM_SLOTS) + 8'(i_coef_slot));
    assign coef_rd_addr = CAW'(8'(band_sel) * 8'(NUM_SLOTS) + 8'(i_cmd.slot));

    generate
        if (COEF_WIDTH >= COEF_IN_W) begin : g_coef_wide
            assign coef_sat = COEF_WIDTH'(i_coef_value);
        end else begin : g_coef_narrow
            localparam logic signed [COEF_IN_W-1:0] C_MAX =
                {{(COEF_IN_W - COEF_WIDTH + 1){1'b0}}, {(COEF_WIDTH - 1){1'b1}}};
            localparam logic signed [COEF_IN_W-1:0] C_MIN = ~C_MAX;
            assign coef_sat = (i_coef_value > C_MAX) ? C_MAX[COEF_WIDTH-1:0] :
                              (i_coef_value < C_MIN) ? C_MIN[COEF_WIDTH-1:0] :
                              i_coef_value[COEF_WIDTH-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && coef_addr_ok) begin
            coef_mem[coef_wr_addr] <= coef_sat;
        end
        if (i_cmd.coef_rd) begin
            r_coef <= coef_mem[coef_rd_addr];
        end
    end

    // A row that was never written since reset reads as zero.
    assign w1 = r_dly_qv ? $signed(r_dly_q[SW-1:0])    : '0;
    assign w2 = r_dly_qv ? $signed(r_dly_q[2*SW-1:SW]) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.dly_wr) begin
            dly_mem[band_sel] <= {w1, r_w0};
        end
        if (i_cmd.dly_rd) begin
            r_dly_q <= dly_mem[band_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_vld <= '0;
            r_dly_qv  <= 1'b0;
        end else begin
            if (i_cmd.dly_wr) begin
                r_dly_vld[band_sel] <= 1'b1;
            end
            if (i_cmd.dly_rd) begin
                r_dly_qv <= r_dly_vld[band_sel];
            end
        end
    end

    always_comb begin
        case (i_cmd.opnd)
            OPND_W1: opnd = w1;
            OPND_W2: opnd = w2;
            OPND_W0: opnd = r_w0;
            default: opnd = '0;
        endcase
    end

    // Q4.20 times Q16.16, rounded half up back to Q16.16.
    assign p_sum   = {r_prod[PW-1], r_prod} + RND_P;
    assign p_rnd   = p_sum[PW:COEF_FRAC];
    assign acc_sat = (r_acc > S_MAX) ? S_MAX[SW-1:0] :
                     (r_acc < S_MIN) ? S_MIN[SW-1:0] : r_acc[SW-1:0];
    assign x_c     = $signed({1'b0, i_sample_in}) - (SAMPLE_W + 1)'(SAMPLE_ZERO);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= r_coef * opnd;
        end
        case (i_cmd.acc_op)
            ACC_Y_SUB: r_acc <= AW'(r_y) - AW'(p_rnd);
            ACC_SUB:   r_acc <= r_acc - AW'(p_rnd);
            ACC_LOAD:  r_acc <= AW'(p_rnd);
            ACC_ADD:   r_acc <= r_acc + AW'(p_rnd);
            default:   r_acc <= r_acc;
        endcase
        if (i_cmd.w0_save) begin
            r_w0 <= acc_sat;
        end
        if (i_cmd.load_x) begin
            r_y <= YW'(x_c) <<< STATE_FRAC;
        end else if (i_cmd.y_sat) begin
            r_y <= YW'(acc_sat);
        end
    end

    // Q16.16 times unsigned Q4.12 gain, rounded half up to an integer sample.
    // The shifted sum is signed, so it is sign-extended before the offset.
    assign g_sum = {r_gprod[GW-1], r_gprod} + RND_G;
    assign g_out = OW'($signed(g_sum[GW:GSH])) + OW'(SAMPLE_ZERO);

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_mul) begin
            r_gprod <= $signed({1'b0, i_out_gain}) * r_y;
        end
        if (i_cmd.out_load) begin
            if (g_out > OW'(SAMPLE_MAX)) begin
                r_audio_out <= SAMPLE_W'(SAMPLE_MAX);
                r_clipped   <= 1'b1;
            end else if (g_out < 0) begin
                r_audio_out <= '0;
                r_clipped   <= 1'b1;
            end else begin
                r_audio_out <= g_out[SAMPLE_W-1:0];
                r_clipped   <= 1'b0;
            end
        end
    end

    assign o_audio_out = r_audio_out;
    assign o_clipped   = r_clipped;

endmodule

// File: rtl/core/cascaded_biquad_equalizer.sv
// Top level of the cascaded biquad equalizer: configuration registers, the
// sequencer and the datapath. Depends on cbeq_pkg, cbeq_ifs, cbeq_ctrl and cbeq_dp.

// The equalizer takes items on i_item and returns one result on o_result for
// every audio sample; coefficient writes produce no result. A coefficient item
// is taken while idle and the port is ready again in the next cycle. A sample runs
// through band_count direct-form-II sections (at most MAX_BANDS) on a single
// shared multiply-accumulate unit fed by a one-port coefficient memory: each
// section forms its five products in turn, and the cascade then finishes the
// last section, runs the gain multiply and loads the output register. When
// the filter is disabled or no section is active, a sample skips the sections
// and goes straight to the gain multiply. The input port accepts a new item
// while a previous result still waits in the output register; a sample only
// stalls at its final step if that earlier result has not been taken.
// The delay state resets to zero through per-band valid bits, so no clearing
// pass is needed. Coefficients are undefined until written, so every active
// band must have all five coefficients loaded before samples are sent.
// Registers sit on an APB-style port: band_count at byte address 0,
// filter_enable at 4 and the output gain (unsigned Q4.12, reset 4096) at 8,
// and are to be written only while the block is idle.
module cascaded_biquad_equalizer #(
    parameter int MAX_BANDS   = 10,
    parameter int COEF_WIDTH  = 24,
    parameter int STATE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cbeq_item_if.sink                     i_item,
    cbeq_result_if.source                 o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbeq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cbeq_pkg::*;

    logic [BAND_CNT_W-1:0] r_band_count;
    logic                  r_filter_enable;
    logic [GAIN_W-1:0]     r_out_gain;
    logic                  cfg_wr;
    logic [1:0]            reg_idx;
    t_dp_cmd               dp_cmd;

    // The register file: a write lands in the access phase of the transfer.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_count    <= '0;
            r_filter_enable <= 1'b0;
            r_out_gain      <= GAIN_W'(1 << GAIN_FRAC);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_BAND_COUNT:    r_band_count    <= pwdata[BAND_CNT_W-1:0];
                REG_FILTER_ENABLE: r_filter_enable <= pwdata[0];
                REG_OUT_GAIN:      r_out_gain      <= pwdata[GAIN_W-1:0];
                default:           r_band_count    <= r_band_count;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BAND_COUNT:    prdata = 32'(r_band_count);
            REG_FILTER_ENABLE: prdata = 32'(r_filter_enable);
            REG_OUT_GAIN:      prdata = 32'(r_out_gain);
            default:           prdata = '0;
        endcase
    end

    // The sequencer owns the handshakes; the datapath owns every payload bit.
    cbeq_ctrl #(
        .MAX_BANDS (MAX_BANDS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (i_item.valid),
        .i_item_op       (i_item.op),
        .o_item_ready    (i_item.ready),
        .o_out_valid     (o_result.valid),
        .i_out_ready     (o_result.ready),
        .i_band_count    (r_band_count),
        .i_filter_enable (r_filter_enable),
        .o_cmd           (dp_cmd)
    );

    cbeq_dp #(
        .MAX_BANDS   (MAX_BANDS),
        .COEF_WIDTH  (COEF_WIDTH),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_sample_in   (i_item.sample_in),
        .i_band_index  (i_item.band_index),
        .i_coef_slot   (i_item.coef_slot),
        .i_coef_value  (i_item.coef_value),
        .i_out_gain    (r_out_gain),
        .o_audio_out   (o_result.audio_out),
        .o_clipped     (o_result.clipped)
    );

    // A coefficient write must never be followed by a fresh result.
    a_coef_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready && (i_item.op == OP_COEF)
        |=> !$rose(o_result.valid))
        else $error("coefficient write produced a result");

    // A sample keeps the input port closed for at least the next cycle.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready && (i_item.op == OP_SAMPLE)
        |=> !i_item.ready)
        else $error("input accepted while a sample is in flight");

    // A clipped result always sits on one of the two rails.
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.clipped
        |-> (o_result.audio_out == '0) ||
            (o_result.audio_out == SAMPLE_W'(SAMPLE_MAX)))
        else $error("clipped flag set on an unsaturated sample");

endmodule
